FILE: hw/rtl/ftach_pkg.sv
// Shared types and constants of the fan tachometer and speed block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package ftach_pkg;

    localparam int RPM_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int PCT_W      = 8;
    localparam int PPR_W      = 8;
    localparam int MININT_W   = 16;
    localparam int WIN_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIVIDEND_W = 22;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd22;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_PPR          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd2;

    localparam logic [PPR_W-1:0]    PPR_RESET    = 8'd2;
    localparam logic [MININT_W-1:0] MININT_RESET = 16'd1000;
    localparam logic [WIN_W-1:0]    WIN_RESET    = 24'd1000000;

    // Percent is clamped to this before scaling to a duty value.
    localparam logic [6:0] PERCENT_MAX = 7'd100;
    // 255 * ceil(2^19 / 100): percent * 255 / 100 becomes a product and a shift.
    localparam logic [27:0] DUTY_RECIP = 28'd1336965;
    localparam int DUTY_SHIFT = 19;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_SPEED = 1'b1
    } ftach_op_t;

    typedef struct packed {
        ftach_op_t         op;
        logic              tach_edge;
        logic [DUTY_W-1:0] duty;
    } ftach_item_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
    } ftach_div_req_t;

    typedef struct packed {
        logic             done;
        logic [RPM_W-1:0] quotient;
    } ftach_div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ftach_front.sv
// Front end: takes input beats, decodes the command and precomputes the duty value.
// Depends on ftach_pkg.
`default_nettype none

module ftach_front (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                s_tuser,
    input  wire logic                s_tach_edge,
    input  wire logic [7:0]          s_percent,
    input  wire logic                q_ready,
    output logic                     q_push,
    output ftach_pkg::ftach_item_t   q_item
);
    import ftach_pkg::*;

    logic [6:0]  pct_clamped;
    logic [27:0] duty_prod;

    assign pct_clamped = (s_percent > PCT_W'(PERCENT_MAX)) ? PERCENT_MAX : s_percent[6:0];
    assign duty_prod   = 28'(pct_clamped) * DUTY_RECIP;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        q_item.op        = s_tuser ? OP_SPEED : OP_TICK;
        q_item.tach_edge = s_tach_edge;
        q_item.duty      = duty_prod[DUTY_SHIFT +: DUTY_W];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ftach_queue.sv
// Small FIFO of decoded items between the front end and the execution back end.
// Depends on ftach_pkg.
`default_nettype none

module ftach_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire ftach_pkg::ftach_item_t push_item,
    output logic                        ready,
    input  wire logic                   pop,
    output logic                        valid,
    output ftach_pkg::ftach_item_t      head
);
    import ftach_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ftach_item_t         mem [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;

    assign ready = (count_reg != CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ftach_div.sv
// Bit-serial restoring divider for the rpm figure, one quotient bit per cycle.
// Depends on ftach_pkg. The quotient is saturated to 16 bits.
`default_nettype none

module ftach_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire ftach_pkg::ftach_div_req_t req,
    input  wire logic [7:0]                divisor,
    output ftach_pkg::ftach_div_rsp_t      rsp
);
    import ftach_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [PPR_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PPR_W:0]        trial;
    logic [PPR_W:0]        diff;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[PPR_W-1:0] : trial[PPR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        rsp.done     = done_reg;
        rsp.quotient = (|quo_reg[DIVIDEND_W-1:RPM_W]) ? {RPM_W{1'b1}} : quo_reg[RPM_W-1:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ftach_back.sv
// Back end: holds the configuration and counters, executes items and drives the
// output register. Depends on ftach_pkg; the rpm division runs in ftach_div.
`default_nettype none

module ftach_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  wire ftach_pkg::ftach_item_t    q_item,
    output logic                           q_pop,
    input  wire logic                      cfg_write,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [23:0]               cfg_data,
    input  wire logic                      m_tready,
    output logic                           m_tvalid,
    output logic [15:0]                    m_rpm,
    output logic                           m_rpm_updated,
    output logic [7:0]                     m_duty,
    output ftach_pkg::ftach_div_req_t      div_req,
    input  wire ftach_pkg::ftach_div_rsp_t div_rsp,
    output logic [7:0]                     divisor
);
    import ftach_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [PPR_W-1:0]    ppr_reg;
    logic [MININT_W-1:0] min_int_reg;
    logic [WIN_W-1:0]    window_reg;

    logic [15:0]         since_reg, since_next;
    logic [15:0]         pulse_reg, pulse_next;
    logic [WIN_W-1:0]    win_cnt_reg, win_cnt_next;
    logic [RPM_W-1:0]    speed_reg, speed_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;

    logic                out_valid_reg, out_valid_next;
    logic [RPM_W-1:0]    out_rpm_reg, out_rpm_next;
    logic                out_upd_reg, out_upd_next;
    logic [DUTY_W-1:0]   out_duty_reg, out_duty_next;

    logic [15:0]         since_inc;
    logic                edge_ok;
    logic [15:0]         pulse_inc;
    logic [WIN_W:0]      win_inc;
    logic                closing;
    logic [DIVIDEND_W-1:0] scaled;
    logic                out_free;

    assign since_inc = (since_reg == 16'hFFFF) ? since_reg : since_reg + 16'd1;
    assign edge_ok   = q_item.tach_edge && (since_inc >= min_int_reg);
    assign pulse_inc = (edge_ok && (pulse_reg != 16'hFFFF)) ? pulse_reg + 16'd1 : pulse_reg;
    assign win_inc   = {1'b0, win_cnt_reg} + (WIN_W + 1)'(1);
    // A window length of zero closes on every tick, the same as one.
    assign closing   = (win_inc >= {1'b0, window_reg});
    // pulses * 60 as (pulses * 64) - (pulses * 4).
    assign scaled    = (DIVIDEND_W'(pulse_inc) << 6) - (DIVIDEND_W'(pulse_inc) << 2);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        since_next     = since_reg;
        pulse_next     = pulse_reg;
        win_cnt_next   = win_cnt_reg;
        speed_next     = speed_reg;
        duty_next      = duty_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_rpm_next   = out_rpm_reg;
        out_upd_next   = out_upd_reg;
        out_duty_next  = out_duty_reg;
        q_pop          = 1'b0;
        div_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_SPEED) begin
                        duty_next      = q_item.duty;
                        out_valid_next = 1'b1;
                        out_rpm_next   = speed_reg;
                        out_upd_next   = 1'b0;
                        out_duty_next  = q_item.duty;
                    end else begin
                        since_next = edge_ok ? 16'd0 : since_inc;
                        if (closing) begin
                            pulse_next   = 16'd0;
                            win_cnt_next = '0;
                            if (pulse_inc == 16'd0) begin
                                speed_next     = '0;
                                out_valid_next = 1'b1;
                                out_rpm_next   = '0;
                                out_upd_next   = 1'b1;
                                out_duty_next  = duty_reg;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = scaled;
                                state_next       = ST_DIV;
                            end
                        end else begin
                            pulse_next     = pulse_inc;
                            win_cnt_next   = win_inc[WIN_W-1:0];
                            out_valid_next = 1'b1;
                            out_rpm_next   = speed_reg;
                            out_upd_next   = 1'b0;
                            out_duty_next  = duty_reg;
                        end
                    end
                end
            end
            ST_DIV: begin
                // The output register was freed when this item was taken.
                if (div_rsp.done) begin
                    speed_next     = div_rsp.quotient;
                    out_valid_next = 1'b1;
                    out_rpm_next   = div_rsp.quotient;
                    out_upd_next   = 1'b1;
                    out_duty_next  = duty_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            since_reg     <= '0;
            pulse_reg     <= '0;
            win_cnt_reg   <= '0;
            speed_reg     <= '0;
            duty_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            since_reg     <= since_next;
            pulse_reg     <= pulse_next;
            win_cnt_reg   <= win_cnt_next;
            speed_reg     <= speed_next;
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_rpm_reg  <= out_rpm_next;
        out_upd_reg  <= out_upd_next;
        out_duty_reg <= out_duty_next;
    end

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg     <= PPR_RESET;
            min_int_reg <= MININT_RESET;
            window_reg  <= WIN_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_PPR:          ppr_reg     <= cfg_data[PPR_W-1:0];
                CFG_MIN_INTERVAL: min_int_reg <= cfg_data[MININT_W-1:0];
                CFG_WINDOW:       window_reg  <= cfg_data[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_rpm         = out_rpm_reg;
    assign m_rpm_updated = out_upd_reg;
    assign m_duty        = out_duty_reg;
    assign divisor       = ppr_reg;

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside a division");

    a_out_empty_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> !out_valid_reg)
        else $error("output register occupied during a division");

    a_rpm_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_rpm_reg == speed_reg)
        else $error("pending rpm differs from held speed");

    a_duty_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_duty_reg == duty_reg)
        else $error("pending duty differs from held duty");

endmodule

`default_nettype wire

FILE: hw/rtl/fan_tach_rpm_meter.sv
// Fan tachometer and speed block. One input beat is either a one-microsecond
// tick (tuser 0, tdata[0] marks a falling tach edge) or a speed request (tuser 1,
// tdata[8:1] the percent). Every input beat gives exactly one output beat with
// the held rpm, a flag set when that tick closed a measurement window, and the
// current duty. The configuration channel writes pulses per revolution (index 0),
// the minimum edge interval (1) and the window length (2); it is always ready
// and the user must write it only while no item is in flight; the block does not
// enforce this. An input beat is held in the queue and then the output register;
// a window-closing tick with pulses counted also waits for the 22-bit quotient
// of a serial divider, one bit per cycle. Other items sustain one beat per cycle
// while the receiver is ready. A two-entry queue between the decoder and the
// executing stage keeps input accepted while a result waits; when the receiver
// stalls the output beat holds and the queue fills, then s_axis_tready drops.
// Reset clears all counters, rpm and duty, empties the queue and restores the
// register defaults; no output beat is pending after reset.
// Depends on ftach_pkg, ftach_front, ftach_queue, ftach_div and ftach_back.
`default_nettype none

module fan_tach_rpm_meter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [0] tach_edge, [8:1] percent, rest zero
    input  wire logic        s_axis_tuser,   // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] rpm, [23:16] duty
    output logic             m_axis_tuser,   // [0] rpm_updated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import ftach_pkg::*;

    ftach_item_t    push_item;
    ftach_item_t    head_item;
    logic           q_push;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    ftach_div_req_t div_req;
    ftach_div_rsp_t div_rsp;
    logic [7:0]     divisor;
    logic [15:0]    rpm;
    logic [7:0]     duty;

    assign cfg_ready = 1'b1;

    ftach_front u_front (
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tuser     (s_axis_tuser),
        .s_tach_edge (s_axis_tdata[0]),
        .s_percent   (s_axis_tdata[8:1]),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    ftach_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    ftach_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .divisor (divisor),
        .rsp     (div_rsp)
    );

    ftach_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tready      (m_axis_tready),
        .m_tvalid      (m_axis_tvalid),
        .m_rpm         (rpm),
        .m_rpm_updated (m_axis_tuser),
        .m_duty        (duty),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .divisor       (divisor)
    );

    assign m_axis_tdata = {duty, rpm};

endmodule

`default_nettype wire
